// ----- src/afp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// afp_pkg: shared types and constants of the article file name parser
// Character codes, parse phases, field widths and digit decode helpers.
// ----------------------------------------------------------------------------
package afp_pkg;

   localparam int CH_W    = 8;
   localparam int ID_W    = 48;
   localparam int ACC_W   = 32;
   localparam int HEX_W   = 12;
   localparam int TYPE_SHIFT = 44;

   localparam logic [CH_W-1:0] CHAR_M   = 8'h4d;
   localparam logic [CH_W-1:0] CHAR_G   = 8'h47;
   localparam logic [CH_W-1:0] CHAR_A   = 8'h41;
   localparam logic [CH_W-1:0] CHAR_DOT = 8'h2e;
   localparam logic [CH_W-1:0] CHAR_0   = 8'h30;
   localparam logic [CH_W-1:0] CHAR_9   = 8'h39;
   localparam logic [CH_W-1:0] CHAR_LA  = 8'h61;
   localparam logic [CH_W-1:0] CHAR_LF  = 8'h66;
   localparam logic [CH_W-1:0] CHAR_UF  = 8'h46;

   localparam logic [ACC_W-1:0] SAT32 = '1;

   typedef enum logic [2:0] {
      PH_TYPE     = 3'd0,
      PH_DOT1     = 3'd1,
      PH_DEC      = 3'd2,
      PH_LETTER_A = 3'd3,
      PH_AFTER_A  = 3'd4,
      PH_HEX      = 3'd5,
      PH_TAIL     = 3'd6
   } phase_type;

   // decoded digit: valid flag and value
   typedef struct packed {
      logic       hit;
      logic [3:0] val;
   } digit_type;

   function automatic digit_type dec_digit(input logic [CH_W-1:0] c);
      digit_type d;
      logic [CH_W-1:0] diff;
      diff  = c - CHAR_0;
      d.hit = (c >= CHAR_0) && (c <= CHAR_9);
      d.val = diff[3:0];
      return d;
   endfunction

   function automatic digit_type hex_digit(input logic [CH_W-1:0] c);
      digit_type d;
      logic [CH_W-1:0] diff;
      d = dec_digit(c);
      if (!d.hit) begin
         if ((c >= CHAR_LA) && (c <= CHAR_LF)) begin
            diff  = c - CHAR_LA + 8'd10;
            d.hit = 1'b1;
            d.val = diff[3:0];
         end else if ((c >= CHAR_A) && (c <= CHAR_UF)) begin
            diff  = c - CHAR_A + 8'd10;
            d.hit = 1'b1;
            d.val = diff[3:0];
         end
      end
      return d;
   endfunction

endpackage
`default_nettype wire

// ----- src/afp_req_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// afp_req_if: character channel
// One character of a file name per beat, with an end-of-name flag.
// ----------------------------------------------------------------------------
interface afp_req_if;
   import afp_pkg::*;

   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;
   logic            last;

   modport source (output valid, output ch, output last, input ready);
   modport sink   (input valid, input ch, input last, output ready);
endinterface
`default_nettype wire

// ----- src/afp_rsp_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// afp_rsp_if: identifier channel
// One packed identifier and its ok flag per beat.
// ----------------------------------------------------------------------------
interface afp_rsp_if;
   import afp_pkg::*;

   logic            valid;
   logic            ready;
   logic [ID_W-1:0] id;
   logic            ok;

   modport source (output valid, output id, output ok, input ready);
   modport sink   (input valid, input id, input ok, output ready);
endinterface
`default_nettype wire

// ----- src/article_filename_id_parser_unit.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// article_filename_id_parser_unit: file name to packed identifier
// Parses T.decimal.A[.hex] one character per beat, one identifier per name.
// ----------------------------------------------------------------------------
// Characters of a name such as "M.1234567890.A.1F3" arrive one per beat on
// req_if, the final one flagged by last. One beat leaves on rsp_if per name,
// carrying id = type<<44 | decimal<<12 | hex[11:0] with ok = 1, or id = 0 and
// ok = 0 for a malformed name. Type is 0 for 'M', 1 for 'G'. Both numbers
// saturate at 2^32-1; an empty digit run counts as 0; anything after the hex
// digits, or after "A" not followed by '.', is ignored. The block takes one
// character every cycle unless a final character waits for the result
// register. A character passes an input register, then the parse logic
// (a times-ten or times-sixteen accumulate with saturation, plus the phase
// update) into the state and result registers, from which the identifier
// is presented.
// The result register stalls only the final character of the next name;
// other characters keep flowing while a result waits.
// ----------------------------------------------------------------------------
module article_filename_id_parser_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   afp_req_if.sink    req_if,
   afp_rsp_if.source  rsp_if
);
   import afp_pkg::*;

   // input register
   logic            s1_valid_ff, s1_valid_in;
   logic [CH_W-1:0] s1_ch_ff;
   logic            s1_last_ff;

   // parse state
   phase_type        phase_ff, phase_in;
   logic             kind_ff, kind_in;
   logic [ACC_W-1:0] dec_acc_ff, dec_acc_in;
   logic [ACC_W-1:0] hex_acc_ff, hex_acc_in;
   logic             failed_ff, failed_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0] rsp_id_ff, rsp_id_in;
   logic            rsp_ok_ff, rsp_ok_in;

   logic out_free;
   logic s1_fire;
   logic req_fire;

   // working values of the step
   digit_type        dd, hd;
   logic [ACC_W+3:0] dec_mac, hex_mac;
   phase_type        ph_n;
   logic             kind_n;
   logic [ACC_W-1:0] dec_n, hex_n;
   logic             fail_n;
   logic             good;

   // the result slot frees when empty or being drained this cycle
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   // only the final beat of a name needs the result slot
   assign s1_fire  = s1_valid_ff && (!s1_last_ff || out_free);
   assign req_if.ready = !s1_valid_ff || s1_fire;
   assign req_fire = req_if.valid && req_if.ready;

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.id    = rsp_id_ff;
   assign rsp_if.ok    = rsp_ok_ff;

   assign s1_valid_in = req_fire ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_fire) begin
         s1_ch_ff   <= req_if.ch;
         s1_last_ff <= req_if.last;
      end
   end

   // one character of parsing
   always_comb begin
      dd = dec_digit(s1_ch_ff);
      hd = hex_digit(s1_ch_ff);
      // acc*10 + d and acc*16 + d, widened to catch overflow
      dec_mac = {1'b0, dec_acc_ff, 3'b000} + {3'b000, dec_acc_ff, 1'b0}
                + {32'd0, dd.val};
      hex_mac = {hex_acc_ff, 4'h0} + {32'd0, hd.val};

      ph_n   = phase_ff;
      kind_n = kind_ff;
      dec_n  = dec_acc_ff;
      hex_n  = hex_acc_ff;
      fail_n = failed_ff;

      if (!failed_ff) begin
         unique case (phase_ff)
            PH_TYPE: begin
               if (s1_ch_ff == CHAR_M) begin
                  kind_n = 1'b0;
                  ph_n   = PH_DOT1;
               end else if (s1_ch_ff == CHAR_G) begin
                  kind_n = 1'b1;
                  ph_n   = PH_DOT1;
               end else begin
                  fail_n = 1'b1;
               end
            end
            PH_DOT1: begin
               if (s1_ch_ff == CHAR_DOT) ph_n = PH_DEC;
               else fail_n = 1'b1;
            end
            PH_DEC: begin
               if (dd.hit) begin
                  dec_n = (dec_mac[ACC_W+3:ACC_W] != 4'd0) ? SAT32 : dec_mac[ACC_W-1:0];
               end else if (s1_ch_ff == CHAR_DOT) begin
                  ph_n = PH_LETTER_A;
               end else begin
                  fail_n = 1'b1;
               end
            end
            PH_LETTER_A: begin
               if (s1_ch_ff == CHAR_A) ph_n = PH_AFTER_A;
               else fail_n = 1'b1;
            end
            PH_AFTER_A: begin
               ph_n = (s1_ch_ff == CHAR_DOT) ? PH_HEX : PH_TAIL;
            end
            PH_HEX: begin
               if (hd.hit) begin
                  hex_n = (hex_mac[ACC_W+3:ACC_W] != 4'd0) ? SAT32 : hex_mac[ACC_W-1:0];
               end else begin
                  ph_n = PH_TAIL;
               end
            end
            PH_TAIL: begin
            end
            default: begin
               fail_n = 1'b1;
            end
         endcase
      end

      good = !fail_n && ((ph_n == PH_AFTER_A) || (ph_n == PH_HEX) || (ph_n == PH_TAIL));

      // state update: a finished name returns everything to reset values
      phase_in   = phase_ff;
      kind_in    = kind_ff;
      dec_acc_in = dec_acc_ff;
      hex_acc_in = hex_acc_ff;
      failed_in  = failed_ff;
      if (s1_fire) begin
         if (s1_last_ff) begin
            phase_in   = PH_TYPE;
            kind_in    = 1'b0;
            dec_acc_in = '0;
            hex_acc_in = '0;
            failed_in  = 1'b0;
         end else begin
            phase_in   = ph_n;
            kind_in    = kind_n;
            dec_acc_in = dec_n;
            hex_acc_in = hex_n;
            failed_in  = fail_n;
         end
      end

      // result slot
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_id_in    = rsp_id_ff;
      rsp_ok_in    = rsp_ok_ff;
      if (s1_fire && s1_last_ff) begin
         rsp_valid_in = 1'b1;
         rsp_ok_in    = good;
         rsp_id_in    = good ? ((ID_W'(kind_n) << TYPE_SHIFT)
                                | {4'h0, dec_n, hex_n[HEX_W-1:0]})
                             : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TYPE;
         kind_ff      <= 1'b0;
         dec_acc_ff   <= '0;
         hex_acc_ff   <= '0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         kind_ff      <= kind_in;
         dec_acc_ff   <= dec_acc_in;
         hex_acc_ff   <= hex_acc_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_id_ff <= rsp_id_in;
      rsp_ok_ff <= rsp_ok_in;
   end

   // a finished name leaves the parser back at the start
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (s1_fire && s1_last_ff) |=> (phase_ff == PH_TYPE) && !failed_ff
                                  && (dec_acc_ff == '0) && (hex_acc_ff == '0))
      else $error("parser state not cleared after final beat");

   // a malformed mark sticks until the name ends
   a_fail_sticky: assert property (@(posedge clock) disable iff (reset)
      (failed_ff && !(s1_fire && s1_last_ff)) |=> failed_ff)
      else $error("failed mark dropped mid-name");

   // a rejected name carries a zero identifier; type field above bit 44 is 0/1
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ok_ff) |-> (rsp_id_ff == '0))
      else $error("non-zero id on failed parse");

   a_type_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_id_ff[ID_W-1:TYPE_SHIFT+1] == '0))
      else $error("type field out of range");

   // a final beat never overwrites an undelivered result
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |=> $stable(rsp_id_ff) && $stable(rsp_ok_ff))
      else $error("pending result overwritten");

endmodule
`default_nettype wire

// ----- verif/afp_id_check_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// afp_id_check_pkg: identifier scoreboard for the file name parser
// Tracks the parse of each name beat by beat, queues the identifier that
// the final character should produce and checks returned beats in order.
// ----------------------------------------------------------------------------
package afp_id_check_pkg;
   import afp_pkg::*;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic            ok;
   } id_beat_type;

   class id_scoreboard;
      phase_type        phase;
      logic             kind;
      logic [ACC_W-1:0] dec_acc;
      logic [ACC_W-1:0] hex_acc;
      logic             failed;
      id_beat_type      expected_ids[$];
      int unsigned      errors;

      function new();
         errors = 0;
         restart_name();
      endfunction

      function void restart_name();
         phase   = PH_TYPE;
         kind    = 1'b0;
         dec_acc = '0;
         hex_acc = '0;
         failed  = 1'b0;
      endfunction

      // acc * base + digit, clipped to all ones as a 32-bit strtoul would
      function logic [ACC_W-1:0] sat_mac(logic [ACC_W-1:0] acc, logic [4:0] base,
                                         logic [3:0] digit);
         logic [ACC_W+7:0] wide;
         wide = acc * base + digit;
         if (wide > {8'd0, SAT32})
            return SAT32;
         return wide[ACC_W-1:0];
      endfunction

      function void parse_char(logic [CH_W-1:0] c);
         logic            dec_hit;
         logic            hex_hit;
         logic [CH_W-1:0] off;
         dec_hit = (c >= CHAR_0) && (c <= CHAR_9);
         hex_hit = 1'b1;
         if (dec_hit)
            off = c - CHAR_0;
         else if ((c >= CHAR_LA) && (c <= CHAR_LF))
            off = c - CHAR_LA + 8'd10;
         else if ((c >= CHAR_A) && (c <= CHAR_UF))
            off = c - CHAR_A + 8'd10;
         else begin
            off     = '0;
            hex_hit = 1'b0;
         end
         if (failed)
            return;
         case (phase)
            PH_TYPE: begin
               if (c == CHAR_M) begin
                  kind  = 1'b0;
                  phase = PH_DOT1;
               end else if (c == CHAR_G) begin
                  kind  = 1'b1;
                  phase = PH_DOT1;
               end else
                  failed = 1'b1;
            end
            PH_DOT1: begin
               if (c == CHAR_DOT) phase = PH_DEC;
               else failed = 1'b1;
            end
            PH_DEC: begin
               if (dec_hit) dec_acc = sat_mac(dec_acc, 5'd10, off[3:0]);
               else if (c == CHAR_DOT) phase = PH_LETTER_A;
               else failed = 1'b1;
            end
            PH_LETTER_A: begin
               if (c == CHAR_A) phase = PH_AFTER_A;
               else failed = 1'b1;
            end
            PH_AFTER_A: begin
               phase = (c == CHAR_DOT) ? PH_HEX : PH_TAIL;
            end
            PH_HEX: begin
               if (hex_hit) hex_acc = sat_mac(hex_acc, 5'd16, off[3:0]);
               else phase = PH_TAIL;
            end
            PH_TAIL: ;
            default: failed = 1'b1;
         endcase
      endfunction

      // accepted character beat; the final one of a name queues an identifier
      function void note_char(logic [CH_W-1:0] c, logic last);
         id_beat_type want;
         parse_char(c);
         if (!last)
            return;
         want.ok = !failed && ((phase == PH_AFTER_A) || (phase == PH_HEX) ||
                               (phase == PH_TAIL));
         want.id = want.ok ? {3'b000, kind, dec_acc, hex_acc[HEX_W-1:0]} : '0;
         expected_ids.push_back(want);
         restart_name();
      endfunction

      function void check_id(logic [ID_W-1:0] id, logic ok);
         id_beat_type want;
         if (expected_ids.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t: unexpected id beat id=%h ok=%b", $realtime, id, ok);
            return;
         end
         want = expected_ids.pop_front();
         if ((id !== want.id) || (ok !== want.ok)) begin
            errors++;
            if (errors <= 10)
               $display("%0t: id mismatch, expected id=%h ok=%b, got id=%h ok=%b",
                        $realtime, want.id, want.ok, id, ok);
         end
      endfunction

      function int unsigned waiting();
         return expected_ids.size();
      endfunction
   endclass

endpackage

// ----- verif/tb_article_filename_id_parser_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_article_filename_id_parser_unit: file name parser testbench
// Streams file names one character per beat under random handshake gaps,
// predicts each identifier with the scoreboard and checks every result beat.
// ----------------------------------------------------------------------------
module tb_article_filename_id_parser_unit;
   import afp_pkg::*;
   import afp_id_check_pkg::*;

   localparam int CHAR_TARGET = 1550;  // character beats to stream in total
   localparam int IDLE_LIMIT  = 2000;  // cycles without any beat before giving up
   localparam int HOLD_AT     = 20;    // result beat that starts the long hold-off
   localparam int HOLD_CYCLES = 300;

   logic clock = 1'b0;
   logic reset;

   afp_req_if req_if ();
   afp_rsp_if rsp_if ();

   article_filename_id_parser_unit uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   id_scoreboard board = new();

   logic [CH_W-1:0] name_chars[$];   // name being built for the sender
   int unsigned     sent_chars = 0;
   int unsigned     rsp_beats  = 0;
   int unsigned     idle_cycles = 0;
   bit              send_calm  = 1'b0;

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Result side: every accepted beat goes to the scoreboard.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         board.check_id(rsp_if.id, rsp_if.ok);
         rsp_beats++;
      end
   end

   // Ready is redrawn at the falling edge after each accepted beat: it drops
   // for a random stall, except in calm stretches. Once, at beat HOLD_AT, it is
   // held low for a long stretch so the parser backs up into its input.
   initial begin : rsp_receiver
      int unsigned stall_left;
      int unsigned seen;
      bit          calm;
      bit          held;
      stall_left = 0;
      seen       = 0;
      calm       = 1'b0;
      held       = 1'b0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_beats != seen) begin
            seen = rsp_beats;
            if ($urandom_range(0, 15) == 0)
               calm = !calm;
            stall_left = calm ? 0 : $urandom_range(0, 6);
            if (!held && seen >= HOLD_AT) begin
               held       = 1'b1;
               stall_left = HOLD_CYCLES;
            end
         end
         if (reset)
            rsp_if.ready <= 1'b0;
         else if (stall_left > 0) begin
            rsp_if.ready <= 1'b0;
            stall_left--;
         end else
            rsp_if.ready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: counts cycles in which neither channel moves a beat.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         idle_cycles <= 0;
      else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("article_filename_id_parser_unit test failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Name building helpers
   // ---------------------------------------------------------------------
   function automatic logic [CH_W-1:0] any_char();
      return CH_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [CH_W-1:0] hex_char();
      int unsigned v;
      v = $urandom_range(0, 21);
      if (v < 10) return CHAR_0 + CH_W'(v);
      if (v < 16) return CHAR_LA + CH_W'(v - 10);
      return CHAR_A + CH_W'(v - 16);
   endfunction

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++)
         name_chars.push_back(s[i]);
   endtask

   // T.decimal.A[.hex][tail] with random content; the decimal run leans on
   // empty runs, short runs, the 2^32 boundary and long runs that may saturate
   task automatic build_good_name();
      int unsigned pick;
      int unsigned n;
      name_chars.delete();
      name_chars.push_back($urandom_range(0, 1) ? CHAR_G : CHAR_M);
      name_chars.push_back(CHAR_DOT);
      pick = $urandom_range(0, 9);
      if (pick == 0)
         n = 0;
      else if (pick < 7)
         n = $urandom_range(1, 6);
      else if (pick == 7) begin
         push_text("42949672");
         n = 2;
      end else
         n = $urandom_range(10, 14);
      repeat (n) name_chars.push_back(CHAR_0 + CH_W'($urandom_range(0, 9)));
      name_chars.push_back(CHAR_DOT);
      name_chars.push_back(CHAR_A);
      pick = $urandom_range(0, 9);
      if (pick >= 2) begin
         if (pick < 8) begin
            name_chars.push_back(CHAR_DOT);
            n = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
            repeat (n) name_chars.push_back(hex_char());
         end else
            name_chars.push_back(any_char());
         repeat ($urandom_range(0, 3)) name_chars.push_back(any_char());
      end
   endtask

   // ---------------------------------------------------------------------
   // Sender: one name, a beat per character, last on the final one.
   // Entered and left at a falling edge.
   // ---------------------------------------------------------------------
   task automatic send_name();
      int unsigned gap;
      for (int i = 0; i < name_chars.size(); i++) begin
         if ($urandom_range(0, 15) == 0)
            send_calm = !send_calm;
         gap = send_calm ? 0 : $urandom_range(0, 6);
         if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         req_if.valid <= 1'b1;
         req_if.ch    <= name_chars[i];
         req_if.last  <= (i == name_chars.size() - 1);
         do @(posedge clock); while (!req_if.ready);
         board.note_char(req_if.ch, req_if.last);
         sent_chars++;
         @(negedge clock);
      end
   endtask

   // sender stands still until every queued identifier has come back
   task automatic drain_ids();
      req_if.valid <= 1'b0;
      while (board.waiting() != 0)
         @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : stimulus
      int unsigned pick;
      bit          paused;
      paused = 1'b0;
      reset        = 1'b1;
      req_if.valid = 1'b0;
      req_if.ch    = '0;
      req_if.last  = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed names: empty decimal ending right after the A, a non-dot
      // after the A, bad type letter, name cut short, sign in the decimal,
      // hex run broken by a non-hex letter, and the all-ones and NUL bytes
      name_chars.delete(); push_text("G..A");     send_name();
      name_chars.delete(); push_text("M.1.Aq");   send_name();
      name_chars.delete(); push_text("Q");        send_name();
      name_chars.delete(); push_text("M");        send_name();
      name_chars.delete(); push_text("M.+");      send_name();
      name_chars.delete(); push_text("G.2.A.fG"); send_name();
      name_chars.delete(); name_chars.push_back(8'hff); send_name();
      name_chars.delete(); push_text("M"); name_chars.push_back(8'h00); send_name();
      drain_ids();

      // random names: mostly well formed, some damaged, some plain noise
      while (sent_chars < CHAR_TARGET) begin
         pick = $urandom_range(0, 99);
         if (pick < 70)
            build_good_name();
         else if (pick < 85) begin
            build_good_name();
            if ($urandom_range(0, 1))
               name_chars[$urandom_range(0, name_chars.size() - 1)] = any_char();
            else begin
               pick = $urandom_range(1, name_chars.size());
               while (name_chars.size() > pick)
                  void'(name_chars.pop_back());
            end
         end else begin
            name_chars.delete();
            repeat ($urandom_range(1, 8)) name_chars.push_back(any_char());
            if ($urandom_range(0, 2) == 0)
               name_chars[0] = CHAR_M;
         end
         send_name();
         if (!paused && sent_chars >= CHAR_TARGET / 2) begin
            paused = 1'b1;
            drain_ids();
         end
      end

      drain_ids();
      repeat (10) @(posedge clock);
      if (board.errors == 0 && board.waiting() == 0)
         $display("article_filename_id_parser_unit test passed");
      else
         $display("article_filename_id_parser_unit test failed");
      $finish;
   end

endmodule

// ----- article_filename_id_parser_unit.f -----
src/afp_pkg.sv
src/afp_req_if.sv
src/afp_rsp_if.sv
src/article_filename_id_parser_unit.sv
verif/afp_id_check_pkg.sv
verif/tb_article_filename_id_parser_unit.sv
